// ----- rtl/core/sled_pkg.sv -----
// ----------------------------------------------------------------------------
// sled_pkg
// Shared types, character codes and helpers for the string literal decoder.
// ----------------------------------------------------------------------------
package sled_pkg;

  typedef enum logic [7:0] {
    PH_IDLE = 8'b0000_0001,
    PH_BODY = 8'b0000_0010,
    PH_ESC  = 8'b0000_0100,
    PH_OCT1 = 8'b0000_1000,
    PH_OCT2 = 8'b0001_0000,
    PH_HEX0 = 8'b0010_0000,
    PH_HEX1 = 8'b0100_0000,
    PH_DONE = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam logic [7:0] QUOTE_RESET = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_B  = 8'h62;
  localparam logic [7:0] CH_LOWER_F  = 8'h66;
  localparam logic [7:0] CH_LOWER_H  = 8'h68;
  localparam logic [7:0] CH_LOWER_N  = 8'h6E;
  localparam logic [7:0] CH_LOWER_R  = 8'h72;
  localparam logic [7:0] CH_LOWER_T  = 8'h74;
  localparam logic [7:0] CH_LOWER_V  = 8'h76;
  localparam logic [7:0] BYTE_MAX    = 8'hFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first;
    logic       final_req;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
    phase_t  phase;
  } plain_t;

  typedef struct packed {
    logic [1:0]       count;
    result_t [2:0]    res;
    phase_t           phase;
    logic [5:0]       octal;
    logic [7:0]       hex;
  } dec_t;

  function automatic logic is_oct(input logic [7:0] b);
    return b inside {[8'h30:8'h37]};
  endfunction

  function automatic logic is_hexd(input logic [7:0] b);
    return b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [3:0] v;
    if (b[6]) begin
      v = b[3:0] + 4'd9;
    end else begin
      v = b[3:0];
    end
    return v;
  endfunction

  function automatic result_t byte_res(input logic [7:0] b);
    result_t r;
    r.data = b;
    r.kind = KIND_BYTE;
    return r;
  endfunction

  function automatic result_t err_res();
    result_t r;
    r.data = '0;
    r.kind = KIND_ERROR;
    return r;
  endfunction

  function automatic plain_t plain_f(input logic [7:0] b, input logic [7:0] q);
    plain_t p;
    p.emit  = 1'b1;
    p.res   = byte_res(b);
    p.phase = PH_BODY;
    if (b == q) begin
      p.res.data = '0;
      p.res.kind = KIND_CLOSE;
      p.phase    = PH_DONE;
    end else if (b == CH_BSLASH) begin
      p.emit  = 1'b0;
      p.phase = PH_ESC;
    end
    return p;
  endfunction

endpackage

// ----- rtl/core/sled_in_if.sv -----
// ----------------------------------------------------------------------------
// sled_in_if
// Source byte channel: valid/ready with one raw byte per beat.
// ----------------------------------------------------------------------------
interface sled_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first;
  logic       final_req;

  modport source (output valid, output in_byte, output first, output final_req,
                  input ready);
  modport sink   (input valid, input in_byte, input first, input final_req,
                  output ready);
endinterface

// ----- rtl/core/sled_out_if.sv -----
// ----------------------------------------------------------------------------
// sled_out_if
// Decoded result channel: valid/ready with one result per beat.
// ----------------------------------------------------------------------------
interface sled_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last,
                  input ready);
  modport sink   (input valid, input out_byte, input kind, input last,
                  output ready);
endinterface

// ----- rtl/core/sled_in_reg.sv -----
// ----------------------------------------------------------------------------
// sled_in_reg
// Input register: holds one source beat until all its results are issued.
// ----------------------------------------------------------------------------
module sled_in_reg import sled_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  sled_in_if.sink   raw,
  input  logic      retire,
  output logic      valid,
  output in_beat_t  item
);

  assign raw.ready = !valid || retire;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (raw.ready) begin
      valid <= raw.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (raw.valid && raw.ready) begin
      item.in_byte   <= raw.in_byte;
      item.first     <= raw.first;
      item.final_req <= raw.final_req;
    end
  end

endmodule

// ----- rtl/core/sled_decode.sv -----
// ----------------------------------------------------------------------------
// sled_decode
// Escape decode of one source byte: up to three results and the next state.
// ----------------------------------------------------------------------------
module sled_decode import sled_pkg::*; (
  input  in_beat_t   item,
  input  phase_t     phase,
  input  logic [5:0] octal_value,
  input  logic [7:0] hex_digit_seen,
  input  logic [7:0] quote_char,
  output dec_t       dec
);

  phase_t     eff_phase;
  plain_t     p1;
  plain_t     p2;
  logic [7:0] b;

  assign b         = item.in_byte;
  assign eff_phase = item.first ? PH_IDLE : phase;

  always_comb begin
    dec.count = 2'd0;
    dec.res   = '0;
    dec.phase = phase;
    dec.octal = octal_value;
    dec.hex   = hex_digit_seen;
    p1        = plain_f(b, quote_char);
    p2        = plain_f(b, quote_char);

    case (eff_phase)
      PH_IDLE: begin
        dec.octal = '0;
        dec.hex   = '0;
        if (b == quote_char) begin
          dec.phase = PH_BODY;
        end else begin
          dec.res[0] = err_res();
          dec.count  = 2'd1;
          dec.phase  = PH_DONE;
        end
      end
      PH_BODY: begin
        dec.res[0] = p1.res;
        dec.count  = {1'b0, p1.emit};
        dec.phase  = p1.phase;
      end
      PH_ESC: begin
        dec.phase  = PH_BODY;
        dec.count  = 2'd1;
        dec.res[0] = byte_res(b);
        case (b)
          CH_LOWER_A: dec.res[0] = byte_res(8'd7);
          CH_LOWER_B: dec.res[0] = byte_res(8'd8);
          CH_LOWER_F: dec.res[0] = byte_res(8'd12);
          CH_LOWER_N: dec.res[0] = byte_res(8'd10);
          CH_LOWER_R: dec.res[0] = byte_res(8'd13);
          CH_LOWER_T: dec.res[0] = byte_res(8'd9);
          CH_LOWER_V: dec.res[0] = byte_res(8'd11);
          CH_LOWER_H: begin
            dec.count = 2'd0;
            dec.phase = PH_HEX0;
          end
          default: begin
            if (is_oct(b)) begin
              dec.count = 2'd0;
              dec.octal = {3'b000, b[2:0]};
              dec.phase = PH_OCT1;
            end
          end
        endcase
      end
      PH_OCT1, PH_OCT2: begin
        if (is_oct(b)) begin
          if (eff_phase == PH_OCT1) begin
            dec.octal = {octal_value[2:0], b[2:0]};
            dec.phase = PH_OCT2;
          end else begin
            dec.count = 2'd1;
            dec.phase = PH_BODY;
            dec.res[0] = octal_value[5] ? byte_res(BYTE_MAX)
                                        : byte_res({octal_value[4:0], b[2:0]});
          end
        end else begin
          dec.res[0] = byte_res({2'b00, octal_value});
          dec.res[1] = p1.res;
          dec.count  = 2'd1 + {1'b0, p1.emit};
          dec.phase  = p1.phase;
        end
      end
      PH_HEX0: begin
        if (is_hexd(b)) begin
          dec.hex   = b;
          dec.phase = PH_HEX1;
        end else begin
          dec.res[0] = byte_res(CH_LOWER_H);
          dec.res[1] = p1.res;
          dec.count  = 2'd1 + {1'b0, p1.emit};
          dec.phase  = p1.phase;
        end
      end
      PH_HEX1: begin
        if (is_hexd(b)) begin
          dec.res[0] = byte_res({hex_val(hex_digit_seen), hex_val(b)});
          dec.count  = 2'd1;
          dec.phase  = PH_BODY;
        end else begin
          // held digit is never a backslash: it closes or is a byte
          p1         = plain_f(hex_digit_seen, quote_char);
          dec.res[0] = byte_res(CH_LOWER_H);
          dec.res[1] = p1.res;
          if (p1.phase == PH_DONE) begin
            dec.count = 2'd2;
            dec.phase = PH_DONE;
          end else begin
            dec.res[2] = p2.res;
            dec.count  = 2'd2 + {1'b0, p2.emit};
            dec.phase  = p2.phase;
          end
        end
      end
      PH_DONE: begin
        dec.phase = PH_DONE;
      end
      default: begin
        dec.phase = PH_DONE;
      end
    endcase

    // end of text before the closing quote
    if (item.final_req && dec.phase != PH_DONE) begin
      dec.res   = '0;
      dec.res[0] = err_res();
      dec.count = 2'd1;
      dec.phase = PH_DONE;
    end
  end

endmodule

// ----- rtl/core/sled_out_reg.sv -----
// ----------------------------------------------------------------------------
// sled_out_reg
// Result register: holds one decoded beat while the receiver stalls.
// ----------------------------------------------------------------------------
module sled_out_reg import sled_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sled_out_if.source decoded,
  input  logic       load,
  input  result_t    res,
  input  logic       res_last,
  output logic       free
);

  assign free = !decoded.valid || decoded.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      decoded.valid <= 1'b0;
    end else if (free) begin
      decoded.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      decoded.out_byte <= res.data;
      decoded.kind     <= res.kind;
      decoded.last     <= res_last;
    end
  end

endmodule

// ----- rtl/core/string_literal_escape_decoder.sv -----
// ----------------------------------------------------------------------------
// string_literal_escape_decoder
// Decodes a quoted string literal with backslash escapes, one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   raw carries source bytes with first and final_req marks; decoded carries
//   result beats (byte, close or error) with last set on the final result of
//   each source byte. cfg_we/cfg_wdata set the quote byte while idle; the
//   user must keep to this, as the block does not enforce it. A source beat
//   is captured in the input register; the decode logic sits between that
//   register and the result register, so each result of a source beat is
//   loaded into the result register once that register is free.
//   Throughput is one source byte per cycle while each byte yields at most
//   one result and the receiver does not stall. A byte that yields several
//   results holds the input register until its last result is loaded.
//   Pending octal or hex digits produce nothing until a later byte decides.
//   Reset clears both registers, sets the quote to a double quote and puts
//   the decoder in its idle phase. When the receiver stalls the result beat
//   holds; source bytes that yield no result still pass, and the first one
//   that yields a result waits in the input register with raw.ready low
//   until results drain.
// ----------------------------------------------------------------------------
module string_literal_escape_decoder import sled_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  sled_in_if.sink    raw,
  sled_out_if.source decoded
);

  logic       item_valid;
  in_beat_t   item;
  dec_t       dec;
  phase_t     phase;
  logic [5:0] octal_value;
  logic [7:0] hex_digit_seen;
  logic [7:0] quote_char;
  logic [1:0] idx;
  logic       out_free;
  logic       load;
  logic       idx_last;
  logic       retire;

  sled_in_reg u_in_reg (
    .clk    (clk),
    .rst    (rst),
    .raw    (raw),
    .retire (retire),
    .valid  (item_valid),
    .item   (item)
  );

  sled_decode u_decode (
    .item           (item),
    .phase          (phase),
    .octal_value    (octal_value),
    .hex_digit_seen (hex_digit_seen),
    .quote_char     (quote_char),
    .dec            (dec)
  );

  assign idx_last = (idx == dec.count - 2'd1);
  assign load     = item_valid && (dec.count != 2'd0) && out_free;
  assign retire   = item_valid && ((dec.count == 2'd0) || (out_free && idx_last));

  sled_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .decoded  (decoded),
    .load     (load),
    .res      (dec.res[idx]),
    .res_last (idx_last),
    .free     (out_free)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (retire) begin
      idx <= 2'd0;
    end else if (load) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      octal_value    <= '0;
      hex_digit_seen <= '0;
    end else if (retire) begin
      phase          <= dec.phase;
      octal_value    <= dec.octal;
      hex_digit_seen <= dec.hex;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_char <= QUOTE_RESET;
    end else if (cfg_we) begin
      quote_char <= cfg_wdata;
    end
  end

endmodule

// ----- rtl/core/sled_checker.sv -----
// ----------------------------------------------------------------------------
// sled_checker
// Port-level checks on the decoder's result channel and input ready, bound to the top level.
// ----------------------------------------------------------------------------
module sled_checker import sled_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       raw_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] kind,
  input logic       last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind)
      && $stable(last))
    else $error("result beat changed under stall");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_BYTE || kind == KIND_CLOSE || kind == KIND_ERROR))
    else $error("undefined result kind");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_BYTE |-> out_byte == 8'h00 && last)
    else $error("close or error beat not zero or not last");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && raw_ready)
    else $error("channels not idle after reset");

endmodule

bind string_literal_escape_decoder sled_checker u_sled_checker (
  .clk       (clk),
  .rst       (rst),
  .raw_ready (raw.ready),
  .out_valid (decoded.valid),
  .out_ready (decoded.ready),
  .out_byte  (decoded.out_byte),
  .kind      (decoded.kind),
  .last      (decoded.last)
);
